>>> sv/wheel_gyro_odometry_integrator_macros.svh
// assertion macros used by the checker
`ifndef WHEEL_GYRO_ODOMETRY_INTEGRATOR_MACROS_SVH
`define WHEEL_GYRO_ODOMETRY_INTEGRATOR_MACROS_SVH

// same-cycle implication
`define WGO_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wgo check failed");

// next-cycle implication
`define WGO_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wgo check failed");

`endif

>>> sv/wgo_pkg.sv
package wgo_pkg;

   typedef struct packed {
      logic signed [31:0] left_distance;
      logic signed [31:0] right_distance;
      logic signed [31:0] gyro_heading;
   } req_type;

   typedef struct packed {
      logic signed [47:0] pos_x;
      logic signed [47:0] pos_y;
      logic [31:0]        heading;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MOD,
      ST_REM,
      ST_FIX,
      ST_SCALE,
      ST_QUO,
      ST_SUM,
      ST_HEAD,
      ST_FOLD,
      ST_ROT,
      ST_ACC
   } state_type;

   localparam int CORDIC_STEPS = 32;
   localparam int CNT_W        = 5;
   localparam int ZW           = 33;
   localparam int REM_W        = 16;

   // 36000 hundredths of a degree per turn
   localparam logic [REM_W-1:0] DIVISOR      = 16'd36000;
   localparam logic [31:0]      HALF_DIVISOR = 32'd18000;

   // 36000 = 32 * 1125; ceil(2^38 / 1125) gives an exact floor for any 27-bit dividend
   localparam logic [27:0] DIV_RECIP   = 28'd244335918;
   localparam int          RECIP_SHIFT = 38;

   // reciprocal of the cordic gain, q30
   localparam logic signed [30:0] INV_GAIN = 31'sd652032874;

   localparam logic signed [47:0] POS_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] POS_MIN = 48'sh8000_0000_0000;

   // arctangent of 2^-i, 2^32 per turn
   function automatic logic [31:0] atan_entry(input logic [CNT_W-1:0] idx);
      logic [31:0] val;
      case (idx)
         5'd0:    val = 32'd536870912;
         5'd1:    val = 32'd316933406;
         5'd2:    val = 32'd167458907;
         5'd3:    val = 32'd85004756;
         5'd4:    val = 32'd42667331;
         5'd5:    val = 32'd21354465;
         5'd6:    val = 32'd10679838;
         5'd7:    val = 32'd5340245;
         5'd8:    val = 32'd2670163;
         5'd9:    val = 32'd1335087;
         5'd10:   val = 32'd667544;
         5'd11:   val = 32'd333772;
         5'd12:   val = 32'd166886;
         5'd13:   val = 32'd83443;
         5'd14:   val = 32'd41722;
         5'd15:   val = 32'd20861;
         5'd16:   val = 32'd10430;
         5'd17:   val = 32'd5215;
         5'd18:   val = 32'd2608;
         5'd19:   val = 32'd1304;
         5'd20:   val = 32'd652;
         5'd21:   val = 32'd326;
         5'd22:   val = 32'd163;
         5'd23:   val = 32'd81;
         5'd24:   val = 32'd41;
         5'd25:   val = 32'd20;
         5'd26:   val = 32'd10;
         5'd27:   val = 32'd5;
         5'd28:   val = 32'd3;
         5'd29:   val = 32'd1;
         5'd30:   val = 32'd1;
         default: val = 32'd0;
      endcase
      return val;
   endfunction

endpackage

>>> sv/wgo_div_step.sv
// division by 36000 through a reciprocal multiply, quotient must fit REM_W bits
// the remainder is taken against a quotient registered in the cycle before
module wgo_div_step import wgo_pkg::*; (
   input  logic [31:0]      num_i,
   input  logic [REM_W-1:0] quo_i,
   output logic [REM_W-1:0] quo_o,
   output logic [REM_W-1:0] rem_o
);

   logic [54:0] prod;
   logic [31:0] back;

   assign prod  = 55'(num_i[31:5]) * 55'(DIV_RECIP);
   assign quo_o = REM_W'(prod >> RECIP_SHIFT);
   assign back  = 32'(quo_i) * 32'(DIVISOR);
   assign rem_o = REM_W'(num_i - back);

endmodule

>>> sv/wgo_cordic_step.sv
// one rotation-mode cordic micro-rotation
module wgo_cordic_step import wgo_pkg::*; #(
   parameter int CW = 50
) (
   input  logic signed [CW-1:0] x_i,
   input  logic signed [CW-1:0] y_i,
   input  logic signed [ZW-1:0] z_i,
   input  logic [CNT_W-1:0]     step_i,
   output logic signed [CW-1:0] x_o,
   output logic signed [CW-1:0] y_o,
   output logic signed [ZW-1:0] z_o
);

   logic signed [CW-1:0] xs;
   logic signed [CW-1:0] ys;
   logic signed [ZW-1:0] at;

   assign xs = x_i >>> step_i;
   assign ys = y_i >>> step_i;
   assign at = ZW'(atan_entry(step_i));

   always_comb begin
      if (!z_i[ZW-1]) begin
         x_o = x_i - ys;
         y_o = y_i + xs;
         z_o = z_i - at;
      end else begin
         x_o = x_i + ys;
         y_o = y_i - xs;
         z_o = z_i + at;
      end
   end

endmodule

>>> sv/wheel_gyro_odometry_integrator.sv
// channel | direction | handshake             | payload
// req     | in        | req_valid / req_stall | req_data: left, right wheel mm, gyro 0.01 deg
// rsp     | out       | rsp_valid / rsp_stall | rsp_data: pos_x, pos_y, heading
//
// the priming transaction after reset only stores the readings and gives no result
// every later transaction keeps req_stall high until its result is loaded for output,
//    so no new transaction is taken while one is in progress
// the work runs through setup states around the shared reciprocal divide-by-36000
//    unit (once for the remainder, once for the angle) and the 32-step cordic rotator
// reset is synchronous and clears the pose, the stored readings and the primed flag
// a stalled result holds in the output register; a new transaction is taken meanwhile,
//    and only the final accumulate waits for the output to drain
module wheel_gyro_odometry_integrator import wgo_pkg::*; #(
   parameter int POS_FRAC_BITS = 16,
   parameter int ANGLE_BITS    = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // cordic datapath width: travel scale plus gain growth plus sign
   localparam int CW = POS_FRAC_BITS + 34;
   // product shift down to the position scale
   localparam int SH = 31 - POS_FRAC_BITS;
   // accumulate width before saturation
   localparam int SW = ((CW > 48) ? CW : 48) + 1;

   // one turn in angle units split as whole multiples of 36000 and the leftover
   localparam logic [63:0]           TURN_UNITS = 64'd1 << ANGLE_BITS;
   localparam logic [ANGLE_BITS-1:0] Q_WHOLE    = ANGLE_BITS'(TURN_UNITS / 64'(DIVISOR));
   localparam logic [REM_W-1:0]      Q_FRAC     = REM_W'(TURN_UNITS % 64'(DIVISOR));

   state_type state_ff, state_in;

   logic [CNT_W-1:0]      cnt_ff;
   logic                  primed_ff;
   logic [31:0]           last_left_ff;
   logic [31:0]           last_right_ff;
   logic [31:0]           last_gyro_ff;
   logic signed [47:0]    acc_x_ff;
   logic signed [47:0]    acc_y_ff;
   logic [31:0]           acc_heading_ff;

   logic signed [32:0]    sum_lr_ff;     // dl + dr
   logic [31:0]           num_ff;        // divider input: |gyro delta|, then scaled remainder
   logic                  dg_pos_ff;     // gyro delta positive, so the angle is negative
   logic [REM_W-1:0]      quo_ff;
   logic [REM_W-1:0]      rem_ff;
   logic [ANGLE_BITS-1:0] qa_ff;
   logic [ANGLE_BITS-1:0] q_ff;
   logic [31:0]           h_ff;
   logic signed [CW-1:0]  v_ff;
   logic signed [CW-1:0]  x_ff;
   logic signed [CW-1:0]  y_ff;
   logic signed [ZW-1:0]  z_ff;

   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;

   // handshake decode
   logic req_take;
   logic load_out;

   // input deltas, taken straight from the ports at accept
   logic [31:0]        dl;
   logic [31:0]        dr;
   logic [31:0]        dg;

   // shared divider
   logic [REM_W-1:0]   div_quo;
   logic [REM_W-1:0]   div_rem;

   // travel scaling
   logic signed [63:0] prod;
   logic signed [63:0] prod_sh;

   // quadrant fold
   logic               fold;
   logic [31:0]        fold_a;

   // rotator step
   logic signed [CW-1:0] x_nx;
   logic signed [CW-1:0] y_nx;
   logic signed [ZW-1:0] z_nx;

   // accumulate and saturate
   logic signed [SW-1:0] sum_x;
   logic signed [SW-1:0] sum_y;
   logic signed [47:0]   sat_x;
   logic signed [47:0]   sat_y;

   // fsm outputs
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      req_take  = req_valid && (state_ff == ST_IDLE);
      load_out  = (state_ff == ST_ACC) && (!rsp_valid_ff || !rsp_stall);
   end

   // fsm next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && primed_ff) state_in = ST_MOD;
         end
         ST_MOD:   state_in = ST_REM;
         ST_REM:   state_in = ST_FIX;
         ST_FIX:   state_in = ST_SCALE;
         ST_SCALE: state_in = ST_QUO;
         ST_QUO:   state_in = ST_SUM;
         ST_SUM:   state_in = ST_HEAD;
         ST_HEAD:  state_in = ST_FOLD;
         ST_FOLD:  state_in = ST_ROT;
         ST_ROT: begin
            if (cnt_ff == CNT_W'(CORDIC_STEPS - 1)) state_in = ST_ACC;
         end
         ST_ACC: begin
            if (load_out) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // wrap-around deltas against the stored readings
   assign dl = req_data.left_distance - last_left_ff;
   assign dr = req_data.right_distance - last_right_ff;
   assign dg = req_data.gyro_heading - last_gyro_ff;

   // first pass reduces |dg| mod 36000, second pass divides the scaled remainder
   wgo_div_step u_div (
      .num_i (num_ff),
      .quo_i (quo_ff),
      .quo_o (div_quo),
      .rem_o (div_rem)
   );

   // mean travel times 1/gain, floor shift to the position scale
   assign prod    = sum_lr_ff * INV_GAIN;
   assign prod_sh = prod >>> SH;

   // second and third quarter turn: negate travel, take a half turn off the angle
   assign fold   = h_ff[31] ^ h_ff[30];
   assign fold_a = fold ? {~h_ff[31], h_ff[30:0]} : h_ff;

   wgo_cordic_step #(
      .CW (CW)
   ) u_rot (
      .x_i    (x_ff),
      .y_i    (y_ff),
      .z_i    (z_ff),
      .step_i (cnt_ff),
      .x_o    (x_nx),
      .y_o    (y_nx),
      .z_o    (z_nx)
   );

   assign sum_x = SW'(acc_x_ff) + SW'(x_ff);
   assign sum_y = SW'(acc_y_ff) + SW'(y_ff);

   always_comb begin
      if (sum_x > SW'(POS_MAX)) begin
         sat_x = POS_MAX;
      end else if (sum_x < SW'(POS_MIN)) begin
         sat_x = POS_MIN;
      end else begin
         sat_x = sum_x[47:0];
      end
      if (sum_y > SW'(POS_MAX)) begin
         sat_y = POS_MAX;
      end else if (sum_y < SW'(POS_MIN)) begin
         sat_y = POS_MIN;
      end else begin
         sat_y = sum_y[47:0];
      end
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cnt_ff         <= '0;
         primed_ff      <= 1'b0;
         last_left_ff   <= '0;
         last_right_ff  <= '0;
         last_gyro_ff   <= '0;
         acc_x_ff       <= '0;
         acc_y_ff       <= '0;
         acc_heading_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (req_take) begin
            primed_ff     <= 1'b1;
            last_left_ff  <= req_data.left_distance;
            last_right_ff <= req_data.right_distance;
            last_gyro_ff  <= req_data.gyro_heading;
         end

         case (state_ff)
            ST_FOLD: cnt_ff <= '0;
            ST_ROT:  cnt_ff <= cnt_ff + 1'b1;
            default: cnt_ff <= cnt_ff;
         endcase

         if (load_out) begin
            acc_x_ff       <= sat_x;
            acc_y_ff       <= sat_y;
            acc_heading_ff <= h_ff;
         end

         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            sum_lr_ff <= 33'(signed'(dl)) + 33'(signed'(dr));
            num_ff    <= dg[31] ? (32'd0 - dg) : dg;
            dg_pos_ff <= !dg[31] && (dg != 32'd0);
         end
         ST_MOD: quo_ff <= div_quo;
         ST_REM: rem_ff <= div_rem;
         ST_FIX: begin
            // negated delta: a nonzero remainder flips to divisor minus remainder
            if (dg_pos_ff && (rem_ff != '0)) rem_ff <= DIVISOR - rem_ff;
         end
         ST_SCALE: begin
            // r * 2^ANGLE_BITS + 18000 = r * whole * 36000 + (r * leftover + 18000)
            qa_ff  <= ANGLE_BITS'(rem_ff) * Q_WHOLE;
            num_ff <= 32'(rem_ff) * 32'(Q_FRAC) + HALF_DIVISOR;
         end
         ST_QUO: quo_ff <= div_quo;
         ST_SUM: q_ff <= qa_ff + ANGLE_BITS'(quo_ff);
         ST_HEAD: begin
            h_ff <= acc_heading_ff + (32'(q_ff) << (32 - ANGLE_BITS));
            v_ff <= prod_sh[CW-1:0];
         end
         ST_FOLD: begin
            x_ff <= fold ? -v_ff : v_ff;
            y_ff <= '0;
            z_ff <= ZW'(signed'(fold_a));
         end
         ST_ROT: begin
            x_ff <= x_nx;
            y_ff <= y_nx;
            z_ff <= z_nx;
         end
         default: begin
         end
      endcase

      if (load_out) begin
         rsp_data_ff.pos_x   <= sat_x;
         rsp_data_ff.pos_y   <= sat_y;
         rsp_data_ff.heading <= h_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> sv/wgo_checker.sv
`include "wheel_gyro_odometry_integrator_macros.svh"

module wgo_checker import wgo_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a reset leaves the block idle with no result pending
   `WGO_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid && !req_stall)

   // an accepted transaction carries known data
   `WGO_ASSERT_NOW(a_req_known, clock, reset, req_valid && !req_stall, !$isunknown(req_data))

   // a stalled result holds
   `WGO_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // a new result only comes out of a busy block
   `WGO_ASSERT_NOW(a_rise_from_busy, clock, reset, $rose(rsp_valid) && !$past(reset), $past(req_stall))

   // going idle again always leaves a result behind
   `WGO_ASSERT_NOW(a_idle_with_result, clock, reset, $fell(req_stall) && !$past(reset), rsp_valid)

endmodule

bind wheel_gyro_odometry_integrator wgo_checker u_wgo_checker (.*);
